[hw/rtl/dfr_pkg.sv]
package dfr_pkg;

    // Default frame buffer depth in bytes
    localparam int BUF_DEPTH_DEF = 64;

    // Delimiter characters
    localparam logic [7:0] FRAME_START = 8'h26;  // '&'
    localparam logic [7:0] FRAME_END   = 8'h2A;  // '*'

    // Number of stored frame fields (positions 1 to 5)
    localparam int FIELD_COUNT = 5;

    // Own address after reset
    localparam logic [7:0] OWN_ADDR_RST = 8'h01;

    typedef logic [7:0] t_byte;

    // One decoded frame as delivered at the output
    typedef struct packed {
        t_byte source;
        t_byte destination;
        t_byte command;
        t_byte relay;
        t_byte payload;
        logic  addressed_to_me;
    } t_frame;

endpackage

[hw/rtl/dfr_in_stage.sv]
module dfr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dfr_pkg::t_byte i_byte,
    input  logic          i_take,
    output logic          o_stage_valid,
    output dfr_pkg::t_byte o_stage_byte
);
    import dfr_pkg::*;

    logic  r_valid;
    t_byte r_byte;

    // Accept a new beat whenever the register is empty or drains this cycle
    assign o_ready = !r_valid || i_take;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the byte
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_stage_valid = r_valid;
    assign o_stage_byte  = r_byte;

`ifndef SYNTHESIS
    // A held byte that is not consumed stays in place
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_take |=> r_valid && $stable(r_byte))
        else $error("input stage lost or changed a pending byte");
`endif

endmodule

[hw/rtl/dfr_frame_core.sv]
module dfr_frame_core #(
    parameter int BUF_DEPTH = dfr_pkg::BUF_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  dfr_pkg::t_byte i_cfg_wdata,
    input  logic           i_stage_valid,
    input  dfr_pkg::t_byte i_stage_byte,
    input  logic           i_out_ready,
    output logic           o_take,
    output logic           o_res_valid,
    output dfr_pkg::t_frame o_res_frame
);
    import dfr_pkg::*;

    localparam int PosW = $clog2(BUF_DEPTH + 1);

    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    t_byte           r_field [FIELD_COUNT];
    t_byte           n_field [FIELD_COUNT];
    t_byte           r_own_addr;
    logic            is_start;
    logic            is_end;
    logic            room;

    assign is_start = (i_stage_byte == FRAME_START);
    assign is_end   = (i_stage_byte == FRAME_END);
    assign room     = (r_pos < PosW'(BUF_DEPTH));

    // Consume a byte unless it closes a frame and the result slot is busy
    assign o_take      = i_stage_valid && (!is_end || i_out_ready);
    assign o_res_valid = o_take && is_end;

    // Store the byte at its field position while the buffer has room
    always_comb begin
        for (int k = 0; k < FIELD_COUNT; k++) begin
            n_field[k] = r_field[k];
            if (room && (r_pos == PosW'(k + 1))) begin
                n_field[k] = i_stage_byte;
            end
        end
    end

    // Advance, saturate, restart or close the position counter
    always_comb begin
        n_pos = r_pos;
        if (room) begin
            n_pos = r_pos + PosW'(1);
        end
        if (is_start) begin
            n_pos = PosW'(1);
        end
        if (is_end) begin
            n_pos = '0;
        end
    end

    // Result from the updated field store
    assign o_res_frame.source          = n_field[0];
    assign o_res_frame.destination     = n_field[1];
    assign o_res_frame.command         = n_field[2];
    assign o_res_frame.relay           = n_field[3];
    assign o_res_frame.payload         = n_field[4];
    assign o_res_frame.addressed_to_me = (n_field[1] == r_own_addr);

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int k = 0; k < FIELD_COUNT; k++) begin
                r_field[k] <= '0;
            end
        end else if (o_take) begin
            r_pos <= n_pos;
            for (int k = 0; k < FIELD_COUNT; k++) begin
                r_field[k] <= n_field[k];
            end
        end
    end

    // Own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RST;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_wdata;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosW'(BUF_DEPTH))
        else $error("frame position ran past buffer depth");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && is_end |=> r_pos == '0)
        else $error("end delimiter did not clear frame position");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && is_start |=> r_pos == PosW'(1))
        else $error("start delimiter did not restart frame position");
`endif

endmodule

[hw/rtl/dfr_out_stage.sv]
module dfr_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_res_valid,
    input  dfr_pkg::t_frame i_res_frame,
    output logic            o_res_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output dfr_pkg::t_frame o_frame
);
    import dfr_pkg::*;

    logic   r_valid;
    t_frame r_frame;

    // Take a new result when empty or when the held one leaves this cycle
    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_frame <= i_res_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> o_res_ready)
        else $error("result written over a beat not yet taken");
`endif

endmodule

[hw/rtl/delimited_frame_receiver_addr_filter_top.sv]
// Frame receiver with address filter. Each input beat is one byte from the
// serial line; '&' restarts a frame and '*' closes it, and only a closing
// '*' produces an output beat carrying the bytes seen at frame positions 1
// to 5 plus a flag that is high when the destination byte equals the own
// address register (reset value 1, written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce). Bytes past BUF_DEPTH in a frame are dropped, but delimiters
// still act. Throughput is one byte per clock; a closing byte waits in the
// input register while the result register holds an untaken beat. A byte
// is held in the input register, its result in the result register, and
// i_ready reaches o_ready combinationally through both stages.
module delimited_frame_receiver_addr_filter_top #(
    parameter int BUF_DEPTH = dfr_pkg::BUF_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  dfr_pkg::t_byte i_cfg_wdata,
    input  logic           i_valid,
    output logic           o_ready,
    input  dfr_pkg::t_byte i_rx_byte,
    output logic           o_valid,
    input  logic           i_ready,
    output dfr_pkg::t_byte o_frame_source,
    output dfr_pkg::t_byte o_frame_destination,
    output dfr_pkg::t_byte o_frame_command,
    output dfr_pkg::t_byte o_frame_relay,
    output dfr_pkg::t_byte o_frame_payload,
    output logic           o_addressed_to_me
);
    import dfr_pkg::*;

    logic   stage_valid;
    t_byte  stage_byte;
    logic   take;
    logic   res_valid;
    logic   res_ready;
    t_frame res_frame;
    t_frame out_frame;

    dfr_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte        (i_rx_byte),
        .i_take        (take),
        .o_stage_valid (stage_valid),
        .o_stage_byte  (stage_byte)
    );

    dfr_frame_core #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_frame_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_stage_valid (stage_valid),
        .i_stage_byte  (stage_byte),
        .i_out_ready   (res_ready),
        .o_take        (take),
        .o_res_valid   (res_valid),
        .o_res_frame   (res_frame)
    );

    dfr_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_frame (res_frame),
        .o_res_ready (res_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_frame     (out_frame)
    );

    assign o_frame_source      = out_frame.source;
    assign o_frame_destination = out_frame.destination;
    assign o_frame_command     = out_frame.command;
    assign o_frame_relay       = out_frame.relay;
    assign o_frame_payload     = out_frame.payload;
    assign o_addressed_to_me   = out_frame.addressed_to_me;

endmodule
